// ----- rtl/dns_query_header_and_name_parser_assert.svh -----
// Assertion helpers for the DNS query parser checker.
// Both sample on clk and are disabled while arst_n is low.
`ifndef DNS_QUERY_HEADER_AND_NAME_PARSER_ASSERT_SVH
`define DNS_QUERY_HEADER_AND_NAME_PARSER_ASSERT_SVH

// Same-cycle implication.
`define DNSQP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dnsqp assertion failed");

// Next-cycle implication.
`define DNSQP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dnsqp assertion failed");

`endif

// ----- rtl/dnsqp_pkg.sv -----
package dnsqp_pkg;

	localparam logic [2:0] KIND_FLAGS    = 3'd0;
	localparam logic [2:0] KIND_COUNT    = 3'd1;
	localparam logic [2:0] KIND_CHAR     = 3'd2;
	localparam logic [2:0] KIND_NAME_END = 3'd3;
	localparam logic [2:0] KIND_ERROR    = 3'd4;

	localparam logic [7:0] DOT_CHAR      = 8'd46;
	localparam logic [7:0] MAX_LABEL_LEN = 8'd63;
	localparam logic [3:0] HDR_LAST_POS  = 4'd11;
	localparam logic [3:0] HDR_FLAGS_POS = 4'd3;
	localparam logic [3:0] HDR_ID_POS    = 4'd1;
	localparam logic [3:0] HDR_QD_POS    = 4'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] msg_id;
		logic        qr;
		logic [3:0]  opcode;
		logic        aa;
		logic        tc;
		logic        rd;
		logic        ra;
		logic [3:0]  rcode;
		logic [1:0]  count_index;
		logic [15:0] count_value;
		logic [7:0]  name_char;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} res_push_t;

endpackage

// ----- rtl/dnsqp_parse.sv -----
module dnsqp_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  dnsqp_pkg::item_t   item,
	input  logic               can_take,
	output dnsqp_pkg::res_push_t push
);
	import dnsqp_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_LEN    = 3'd2;
	localparam logic [2:0] PH_LABEL  = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	logic        valid_s1;
	item_t       item_s1;

	logic [2:0]  phase_q;
	logic [3:0]  hdr_pos_q;
	logic [7:0]  high_byte_q;
	logic [15:0] held_id_q;
	logic [5:0]  label_rem_q;
	logic        seen_label_q;

	logic [2:0]  phase_d;
	logic [3:0]  hdr_pos_d;
	logic [7:0]  high_byte_d;
	logic [15:0] held_id_d;
	logic [5:0]  label_rem_d;
	logic        seen_label_d;
	logic        has_res;
	result_t     res;
	logic        fire;

	assign fire       = valid_s1 && can_take;
	assign item_ready = !valid_s1 || can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		logic [2:0]  ph;
		logic [15:0] word;
		logic [3:0]  cnt_off;
		ph           = item_s1.first ? PH_HEADER : phase_q;
		hdr_pos_d    = item_s1.first ? 4'd0 : hdr_pos_q;
		high_byte_d  = item_s1.first ? 8'd0 : high_byte_q;
		held_id_d    = item_s1.first ? 16'd0 : held_id_q;
		label_rem_d  = item_s1.first ? 6'd0 : label_rem_q;
		seen_label_d = item_s1.first ? 1'b0 : seen_label_q;
		phase_d      = ph;
		has_res      = 1'b0;
		res          = '0;
		word         = {high_byte_d, item_s1.data_byte};
		cnt_off      = hdr_pos_d - HDR_QD_POS;
		unique case (ph)
			PH_HEADER: begin
				hdr_pos_d = hdr_pos_d + 4'd1;
				if (hdr_pos_q == HDR_LAST_POS && !item_s1.first) begin
					phase_d = PH_LEN;
				end
				if (!(item_s1.first ? 1'b0 : hdr_pos_q[0])) begin
					high_byte_d = item_s1.data_byte;
				end else if ((item_s1.first ? 4'd0 : hdr_pos_q) == HDR_ID_POS) begin
					held_id_d = word;
				end else if (hdr_pos_q == HDR_FLAGS_POS) begin
					has_res      = 1'b1;
					res.kind     = KIND_FLAGS;
					res.msg_id   = held_id_d;
					res.qr       = word[15];
					res.opcode   = word[14:11];
					res.aa       = word[10];
					res.tc       = word[9];
					res.rd       = word[8];
					res.ra       = word[7];
					res.rcode    = word[3:0];
				end else begin
					has_res         = 1'b1;
					res.kind        = KIND_COUNT;
					res.count_index = cnt_off[2:1];
					res.count_value = word;
				end
			end
			PH_LEN: begin
				if (item_s1.data_byte == 8'd0) begin
					has_res  = 1'b1;
					res.kind = KIND_NAME_END;
					phase_d  = PH_DONE;
				end else if (item_s1.data_byte > MAX_LABEL_LEN) begin
					has_res  = 1'b1;
					res.kind = KIND_ERROR;
					phase_d  = PH_DONE;
				end else begin
					label_rem_d = item_s1.data_byte[5:0];
					phase_d     = PH_LABEL;
					if (seen_label_d) begin
						has_res       = 1'b1;
						res.kind      = KIND_CHAR;
						res.name_char = DOT_CHAR;
					end
					seen_label_d = 1'b1;
				end
			end
			PH_LABEL: begin
				has_res       = 1'b1;
				res.kind      = KIND_CHAR;
				res.name_char = item_s1.data_byte;
				if (label_rem_d != 6'd0) begin
					label_rem_d = label_rem_d - 6'd1;
				end
				if (label_rem_d == 6'd0) begin
					phase_d = PH_LEN;
				end
			end
			default: begin
				// idle or done: drop the byte
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hdr_pos_q    <= 4'd0;
			high_byte_q  <= 8'd0;
			held_id_q    <= 16'd0;
			label_rem_q  <= 6'd0;
			seen_label_q <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_d;
			hdr_pos_q    <= hdr_pos_d;
			high_byte_q  <= high_byte_d;
			held_id_q    <= held_id_d;
			label_rem_q  <= label_rem_d;
			seen_label_q <= seen_label_d;
		end
	end

	assign push.valid = fire && has_res;
	assign push.data  = res;

endmodule

// ----- rtl/dnsqp_out_reg.sv -----
module dnsqp_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dnsqp_pkg::res_push_t push,
	output logic                 can_take,
	output logic                 result_valid,
	input  logic                 result_ready,
	output dnsqp_pkg::result_t   result
);
	import dnsqp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign can_take     = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.valid) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			data_q <= push.data;
		end
	end

endmodule

// ----- rtl/dns_query_header_and_name_parser.sv -----
// Parses a DNS query one byte per transfer: the 12-byte header gives a flags result
// (ID plus decoded QR, opcode, AA, TC, RD, RA, RCODE) and four section count results,
// then each QNAME label byte comes out as a name character, with a dot between labels,
// a name-end result at the zero length byte and an error result for a length above 63.
// Bytes before the first-byte flag, or after name end or error, give no result.
// Sustained rate is one byte per cycle while result_ready is high; a result passes from
// the input register through the result register to the output. item_ready follows
// result_ready combinationally when both stages are full.
module dns_query_header_and_name_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  dnsqp_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output dnsqp_pkg::result_t result
);
	import dnsqp_pkg::*;

	res_push_t push;
	logic      can_take;

	dnsqp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.can_take   (can_take),
		.push       (push)
	);

	dnsqp_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.can_take     (can_take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- rtl/dnsqp_checker.sv -----
`include "dns_query_header_and_name_parser_assert.svh"

module dnsqp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input dnsqp_pkg::item_t   item,
	input logic               result_valid,
	input logic               result_ready,
	input dnsqp_pkg::result_t result
);
	import dnsqp_pkg::*;

	// hold an offered byte until it transfers
	`DNSQP_ASSERT_NEXT(a_item_hold, item_valid && !item_ready,
		item_valid && $stable(item))

	// hold a stalled result
	`DNSQP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
		result_valid && $stable(result))

	// an empty output side never blocks input
	`DNSQP_ASSERT_NOW(a_ready_when_empty, !result_valid, item_ready)

	`DNSQP_ASSERT_NOW(a_count_fields_zero, result_valid && result.kind != KIND_COUNT,
		result.count_index == 2'd0 && result.count_value == 16'd0)

	`DNSQP_ASSERT_NOW(a_flag_fields_zero, result_valid && result.kind != KIND_FLAGS,
		result.msg_id == 16'd0 && result.opcode == 4'd0 && result.rcode == 4'd0 && !result.qr)

endmodule

bind dns_query_header_and_name_parser dnsqp_checker u_dnsqp_checker (.*);
